[rtl/core/ifs_pkg.sv]
// Package for the image format sniffer: signature bytes, format codes,
// and the TGA field checks. No dependencies.
`default_nettype none
package ifs_pkg;

	localparam int unsigned POS_W  = 5;
	localparam int unsigned CODE_W = 3;

	typedef logic [7:0]        byte_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [CODE_W-1:0] code_t;

	localparam code_t FMT_UNKNOWN = 3'd0;
	localparam code_t FMT_PNG     = 3'd1;
	localparam code_t FMT_JPEG    = 3'd2;
	localparam code_t FMT_BMP     = 3'd3;
	localparam code_t FMT_WEBP    = 3'd4;
	localparam code_t FMT_TGA     = 3'd5;

	localparam pos_t LEN_PNG  = 5'd8;
	localparam pos_t LEN_JPEG = 5'd3;
	localparam pos_t LEN_BMP  = 5'd2;
	localparam pos_t LEN_RIFF = 5'd4;
	localparam pos_t OFS_WEBP = 5'd8;
	localparam pos_t END_WEBP = 5'd12;
	localparam pos_t OFS_CMAP = 5'd1;
	localparam pos_t OFS_TYPE = 5'd2;
	localparam pos_t OFS_W_LO = 5'd12;
	localparam pos_t OFS_W_HI = 5'd13;
	localparam pos_t OFS_H_LO = 5'd14;
	localparam pos_t OFS_H_HI = 5'd15;
	localparam pos_t OFS_DEPTH = 5'd16;
	localparam pos_t POS_END  = 5'd18;

	localparam byte_t PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam byte_t JPEG_SIG [3] = '{8'hFF, 8'hD8, 8'hFF};
	localparam byte_t BMP_SIG  [2] = '{8'h42, 8'h4D};
	localparam byte_t RIFF_SIG [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
	localparam byte_t WEBP_SIG [4] = '{8'h57, 8'h45, 8'h42, 8'h50};

	function automatic logic tga_type_ok(byte_t t);
		return (t == 8'd1) || (t == 8'd2) || (t == 8'd3) ||
			(t == 8'd9) || (t == 8'd10) || (t == 8'd11);
	endfunction

	function automatic logic tga_depth_ok(byte_t d);
		return (d == 8'd8) || (d == 8'd15) || (d == 8'd16) ||
			(d == 8'd24) || (d == 8'd32);
	endfunction

endpackage
`default_nettype wire

[rtl/core/ifs_match.sv]
// Running signature match state and format decision for one file.
// Depends on ifs_pkg.
`default_nettype none
module ifs_match (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire ifs_pkg::byte_t data_byte,
	input  wire logic          is_last,
	output ifs_pkg::code_t     code
);
	import ifs_pkg::*;

	pos_t pos_q, pos_d;
	logic png_q, jpeg_q, bmp_q, webp_q, tga_q, wnz_q, hnz_q;
	logic png_d, jpeg_d, bmp_d, webp_d, tga_d, wnz_d, hnz_d;
	logic in_win;

	always_comb begin
		in_win = pos_q < POS_END;
		png_d  = png_q;
		jpeg_d = jpeg_q;
		bmp_d  = bmp_q;
		webp_d = webp_q;
		tga_d  = tga_q;
		wnz_d  = wnz_q;
		hnz_d  = hnz_q;
		pos_d  = pos_q;
		if (in_win) begin
			pos_d = pos_q + 5'd1;
			if (pos_q < LEN_PNG && data_byte != PNG_SIG[pos_q[2:0]])
				png_d = 1'b0;
			if (pos_q < LEN_JPEG && data_byte != JPEG_SIG[pos_q[1:0]])
				jpeg_d = 1'b0;
			if (pos_q < LEN_BMP && data_byte != BMP_SIG[pos_q[0]])
				bmp_d = 1'b0;
			if (pos_q < LEN_RIFF && data_byte != RIFF_SIG[pos_q[1:0]])
				webp_d = 1'b0;
			if (pos_q >= OFS_WEBP && pos_q < END_WEBP &&
					data_byte != WEBP_SIG[pos_q[1:0]])
				webp_d = 1'b0;
			if (pos_q == OFS_CMAP && data_byte > 8'd1)
				tga_d = 1'b0;
			if (pos_q == OFS_TYPE && !tga_type_ok(data_byte))
				tga_d = 1'b0;
			if (pos_q == OFS_DEPTH && !tga_depth_ok(data_byte))
				tga_d = 1'b0;
			if ((pos_q == OFS_W_LO || pos_q == OFS_W_HI) && data_byte != 8'd0)
				wnz_d = 1'b1;
			if ((pos_q == OFS_H_LO || pos_q == OFS_H_HI) && data_byte != 8'd0)
				hnz_d = 1'b1;
		end

		// priority: png, jpeg, bmp, webp, tga
		if (png_d && pos_d >= LEN_PNG)
			code = FMT_PNG;
		else if (jpeg_d && pos_d >= LEN_JPEG)
			code = FMT_JPEG;
		else if (bmp_d && pos_d >= LEN_BMP)
			code = FMT_BMP;
		else if (webp_d && pos_d >= END_WEBP)
			code = FMT_WEBP;
		else if (tga_d && wnz_d && hnz_d && pos_d >= POS_END)
			code = FMT_TGA;
		else
			code = FMT_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			png_q  <= 1'b1;
			jpeg_q <= 1'b1;
			bmp_q  <= 1'b1;
			webp_q <= 1'b1;
			tga_q  <= 1'b1;
			wnz_q  <= 1'b0;
			hnz_q  <= 1'b0;
		end else if (step) begin
			if (is_last) begin
				// start over for the next file
				pos_q  <= '0;
				png_q  <= 1'b1;
				jpeg_q <= 1'b1;
				bmp_q  <= 1'b1;
				webp_q <= 1'b1;
				tga_q  <= 1'b1;
				wnz_q  <= 1'b0;
				hnz_q  <= 1'b0;
			end else begin
				pos_q  <= pos_d;
				png_q  <= png_d;
				jpeg_q <= jpeg_d;
				bmp_q  <= bmp_d;
				webp_q <= webp_d;
				tga_q  <= tga_d;
				wnz_q  <= wnz_d;
				hnz_q  <= hnz_d;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/ifs_out.sv]
// Two-entry result buffer: output register plus skid slot for format codes.
// Depends on ifs_pkg.
`default_nettype none
module ifs_out (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire ifs_pkg::code_t push_code,
	output logic                full,
	output ifs_pkg::code_t      format_code,
	output logic                code_valid,
	input  wire logic           code_ready
);
	import ifs_pkg::*;

	logic [1:0] count_q;
	code_t      head_q, tail_q;
	logic       pop;

	assign code_valid  = count_q != 2'd0;
	assign full        = count_q == 2'd2;
	assign format_code = head_q;
	assign pop         = code_valid && code_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			// advance the tail into the head
			if (count_q == 2'd2)
				head_q <= tail_q;
			else if (push)
				head_q <= push_code;
			if (push)
				tail_q <= push_code;
		end else if (push) begin
			if (count_q == 2'd0)
				head_q <= push_code;
			else
				tail_q <= push_code;
		end
	end

endmodule
`default_nettype wire

[rtl/core/image_format_sniffer_unit.sv]
// Top level of the image format sniffer: input register, match tracker,
// result buffer. Depends on ifs_pkg, ifs_match, ifs_out.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   byte    | byte_valid, byte_ready, data_byte,   | in
//           | is_last                              |
//   code    | code_valid, code_ready, format_code  | out
//
// One byte per cycle sustained. A byte transfer lands in the input register and
// then updates the match state; the final byte's update also pushes its code
// into the result buffer, onto format_code if empty. The two-entry result
// buffer lets bytes keep flowing while a code waits; bytes stall only with
// both slots full and a final byte in the input register. Reset needs no sweep.
`default_nettype none
module image_format_sniffer_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           byte_valid,
	output logic                byte_ready,
	input  wire ifs_pkg::byte_t data_byte,
	input  wire logic           is_last,
	output logic                code_valid,
	input  wire logic           code_ready,
	output ifs_pkg::code_t      format_code
);
	import ifs_pkg::*;

	logic  valid_s1, last_s1;
	byte_t byte_s1;
	logic  adv_s1, buf_full;
	code_t code;

	// a final byte needs a free result slot, other bytes always drain
	assign adv_s1     = valid_s1 && (!last_s1 || !buf_full);
	assign byte_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= is_last;
		end
	end

	ifs_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (byte_s1),
		.is_last   (last_s1),
		.code      (code)
	);

	ifs_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (adv_s1 && last_s1),
		.push_code   (code),
		.full        (buf_full),
		.format_code (format_code),
		.code_valid  (code_valid),
		.code_ready  (code_ready)
	);

endmodule
`default_nettype wire

[sim/ifs_sniff_checker.sv]
// Checker for the image format sniffer: watches the byte and code channels,
// predicts each file's format code and compares it with what the block returns.
// Depends on ifs_pkg for the port types and format codes.
module ifs_sniff_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic            byte_ready,
	input  ifs_pkg::byte_t  data_byte,
	input  logic            is_last,
	input  logic            code_valid,
	input  logic            code_ready,
	input  ifs_pkg::code_t  format_code,
	output int              fail_count,
	output int              codes_pending,
	output int              bytes_seen,
	output int              files_checked,
	output logic [7:0]      formats_hit
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SCAN_BYTES = 18;

	localparam ifs_pkg::byte_t PNG_MAGIC  [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam ifs_pkg::byte_t JPEG_MAGIC [3] = '{8'hFF, 8'hD8, 8'hFF};
	localparam ifs_pkg::byte_t BMP_MAGIC  [2] = '{8'h42, 8'h4D};
	localparam ifs_pkg::byte_t RIFF_MAGIC [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
	localparam ifs_pkg::byte_t WEBP_MAGIC [4] = '{8'h57, 8'h45, 8'h42, 8'h50};

	ifs_pkg::pos_t  scan_pos;
	logic           png_ok, jpeg_ok, bmp_ok, webp_ok, tga_ok, width_seen, height_seen;
	ifs_pkg::code_t expected_codes [$];
	ifs_pkg::code_t want;

	initial begin
		fail_count    = 0;
		codes_pending = 0;
		bytes_seen    = 0;
		files_checked = 0;
		formats_hit   = '0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_scan();
		scan_pos    = '0;
		png_ok      = 1'b1;
		jpeg_ok     = 1'b1;
		bmp_ok      = 1'b1;
		webp_ok     = 1'b1;
		tga_ok      = 1'b1;
		width_seen  = 1'b0;
		height_seen = 1'b0;
	endtask

	// Fold one byte into the match state; on the final byte queue the code.
	task automatic scan_byte(input ifs_pkg::byte_t b, input logic last);
		ifs_pkg::code_t code;
		if (scan_pos < SCAN_BYTES) begin
			if (scan_pos < 8 && b != PNG_MAGIC[scan_pos]) png_ok = 1'b0;
			if (scan_pos < 3 && b != JPEG_MAGIC[scan_pos]) jpeg_ok = 1'b0;
			if (scan_pos < 2 && b != BMP_MAGIC[scan_pos]) bmp_ok = 1'b0;
			if (scan_pos < 4 && b != RIFF_MAGIC[scan_pos]) webp_ok = 1'b0;
			if (scan_pos >= 8 && scan_pos < 12 && b != WEBP_MAGIC[scan_pos - 8])
				webp_ok = 1'b0;
			if (scan_pos == 1 && b > 8'd1) tga_ok = 1'b0;
			if (scan_pos == 2) begin
				case (b)
					8'd1, 8'd2, 8'd3, 8'd9, 8'd10, 8'd11: ;
					default: tga_ok = 1'b0;
				endcase
			end
			if (scan_pos == 16) begin
				case (b)
					8'd8, 8'd15, 8'd16, 8'd24, 8'd32: ;
					default: tga_ok = 1'b0;
				endcase
			end
			if ((scan_pos == 12 || scan_pos == 13) && b != 8'd0) width_seen = 1'b1;
			if ((scan_pos == 14 || scan_pos == 15) && b != 8'd0) height_seen = 1'b1;
			scan_pos = scan_pos + 1'b1;
		end
		if (last) begin
			// priority order: png, jpeg, bmp, webp, tga
			if (png_ok && scan_pos >= 8)
				code = ifs_pkg::FMT_PNG;
			else if (jpeg_ok && scan_pos >= 3)
				code = ifs_pkg::FMT_JPEG;
			else if (bmp_ok && scan_pos >= 2)
				code = ifs_pkg::FMT_BMP;
			else if (webp_ok && scan_pos >= 12)
				code = ifs_pkg::FMT_WEBP;
			else if (tga_ok && width_seen && height_seen && scan_pos >= SCAN_BYTES)
				code = ifs_pkg::FMT_TGA;
			else
				code = ifs_pkg::FMT_UNKNOWN;
			expected_codes.push_back(code);
			clear_scan();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_scan();
			expected_codes.delete();
		end else begin
			if (byte_valid && byte_ready) begin
				bytes_seen++;
				scan_byte(data_byte, is_last);
			end
			if (code_valid && code_ready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch($sformatf("format_code %0d with no file pending",
						format_code));
				end else begin
					want = expected_codes.pop_front();
					files_checked++;
					formats_hit[want] = 1'b1;
					if (format_code !== want)
						report_mismatch($sformatf("file %0d: format_code %0d, want %0d",
							files_checked, format_code, want));
				end
			end
		end
		codes_pending <= expected_codes.size();
	end

endmodule

[sim/tb_image_format_sniffer_unit.sv]
// Testbench top for image_format_sniffer_unit: clock, reset, file stimulus,
// receiver back-pressure and the verdict. Depends on ifs_pkg, the block and
// ifs_sniff_checker.
module tb_image_format_sniffer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int K_PNG   = 0;
	localparam int K_JPEG  = 1;
	localparam int K_BMP   = 2;
	localparam int K_WEBP  = 3;
	localparam int K_TGA   = 4;
	localparam int K_NOISE = 5;

	localparam int PHASE_BYTES = 340;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           byte_valid = 1'b0;
	logic           byte_ready;
	ifs_pkg::byte_t data_byte = '0;
	logic           is_last = 1'b0;
	logic           code_valid;
	logic           code_ready = 1'b0;
	ifs_pkg::code_t format_code;

	int             fail_count, codes_pending, bytes_seen, files_checked;
	logic [7:0]     formats_hit;

	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             hold_left = 0;
	ifs_pkg::byte_t payload [$];

	always #10 clk = ~clk;

	image_format_sniffer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.data_byte   (data_byte),
		.is_last     (is_last),
		.code_valid  (code_valid),
		.code_ready  (code_ready),
		.format_code (format_code)
	);

	ifs_sniff_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_ready    (byte_ready),
		.data_byte     (data_byte),
		.is_last       (is_last),
		.code_valid    (code_valid),
		.code_ready    (code_ready),
		.format_code   (format_code),
		.fail_count    (fail_count),
		.codes_pending (codes_pending),
		.bytes_seen    (bytes_seen),
		.files_checked (files_checked),
		.formats_hit   (formats_hit)
	);

	// Receiver: long hold-off when requested, random stalls otherwise.
	always @(posedge clk) begin
		if (!arst_n) begin
			code_ready <= 1'b0;
		end else if (hold_left > 0) begin
			code_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			code_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_byte(input ifs_pkg::byte_t b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		is_last    <= last;
		do @(posedge clk); while (!byte_ready);
	endtask

	task automatic send_file();
		int i;
		for (i = 0; i < payload.size(); i++)
			send_byte(payload[i], i == payload.size() - 1);
	endtask

	// Drop valid and hold until every queued code has come back.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (codes_pending != 0);
	endtask

	// Build one file: mostly a well-formed header with random content, some of
	// it truncated or with one header byte corrupted, the rest plain noise.
	task automatic compose_file();
		int kind, len, pick, i, cut;
		pick = $urandom_range(99);
		kind = (pick < 80) ? $urandom_range(K_PNG, K_TGA) : K_NOISE;
		pick = $urandom_range(19);
		if (pick < 3) begin
			len = $urandom_range(1, 11);
		end else if (pick < 6) begin
			case ($urandom_range(7))
				0: len = 2;
				1: len = 3;
				2: len = 7;
				3: len = 8;
				4: len = 11;
				5: len = 12;
				6: len = 17;
				default: len = 18;
			endcase
		end else if (pick == 6) begin
			len = $urandom_range(30, 60);
		end else begin
			len = $urandom_range(12, 26);
		end
		payload.delete();
		for (i = 0; i < len; i++)
			payload.push_back(ifs_pkg::byte_t'($urandom));
		case (kind)
			K_PNG: begin
				for (i = 0; i < 8 && i < len; i++) payload[i] = ifs_pkg::PNG_SIG[i];
			end
			K_JPEG: begin
				for (i = 0; i < 3 && i < len; i++) payload[i] = ifs_pkg::JPEG_SIG[i];
			end
			K_BMP: begin
				for (i = 0; i < 2 && i < len; i++) payload[i] = ifs_pkg::BMP_SIG[i];
			end
			K_WEBP: begin
				for (i = 0; i < 4 && i < len; i++) payload[i] = ifs_pkg::RIFF_SIG[i];
				for (i = 8; i < 12 && i < len; i++) payload[i] = ifs_pkg::WEBP_SIG[i - 8];
			end
			K_TGA: begin
				if (len > 1) payload[1] = ifs_pkg::byte_t'($urandom_range(1));
				if (len > 2) begin
					case ($urandom_range(5))
						0: payload[2] = 8'd1;
						1: payload[2] = 8'd2;
						2: payload[2] = 8'd3;
						3: payload[2] = 8'd9;
						4: payload[2] = 8'd10;
						default: payload[2] = 8'd11;
					endcase
				end
				if (len > 16) begin
					case ($urandom_range(4))
						0: payload[16] = 8'd8;
						1: payload[16] = 8'd15;
						2: payload[16] = 8'd16;
						3: payload[16] = 8'd24;
						default: payload[16] = 8'd32;
					endcase
				end
				// zero none, one or both bytes of width and of height
				if (len > 13) begin
					pick = $urandom_range(3);
					if (pick == 0 || pick == 1) payload[12] = 8'd0;
					if (pick == 0 || pick == 2) payload[13] = 8'd0;
				end
				if (len > 15) begin
					pick = $urandom_range(3);
					if (pick == 0 || pick == 1) payload[14] = 8'd0;
					if (pick == 0 || pick == 2) payload[15] = 8'd0;
				end
			end
			default: begin
				// start noise on a signature's first byte now and then
				case ($urandom_range(7))
					0: payload[0] = 8'h89;
					1: payload[0] = 8'hFF;
					2: payload[0] = 8'h42;
					3: payload[0] = 8'h52;
					default: ;
				endcase
			end
		endcase
		if (kind != K_NOISE && $urandom_range(4) == 0) begin
			cut = $urandom_range((len < 18 ? len : 18) - 1);
			payload[cut] = payload[cut] ^ ifs_pkg::byte_t'($urandom_range(1, 255));
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int sent;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			compose_file();
			send_file();
			sent += payload.size();
		end
		wait_drained();
	endtask

	initial begin
		int i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short files around the PNG, JPEG and BMP signature lengths and the byte extremes
		payload = '{8'h00};                   send_file();
		payload = '{8'hFF};                   send_file();
		payload = '{8'h42};                   send_file();
		payload = '{8'h42, 8'h4D};            send_file();
		payload = '{8'hFF, 8'hD8};            send_file();
		payload = '{8'hFF, 8'hD8, 8'hFF};     send_file();
		payload = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
		send_file();
		wait_drained();

		// hold the receiver off while tiny files keep coming, so input stalls
		hold_left = 300;
		for (i = 0; i < 40; i++) begin
			payload = '{ifs_pkg::byte_t'($urandom)};
			if (i % 3 == 0) payload.push_back(ifs_pkg::byte_t'($urandom));
			send_file();
		end
		wait_drained();

		run_phase(0, 0);
		run_phase(79, 0);
		run_phase(0, 79);
		run_phase(33, 33);

		repeat (10) @(posedge clk);
		$display("Sniffed %0d bytes in %0d files: directed headers, back-pressure,",
			bytes_seen, files_checked);
		$display("four idle mixes. Format codes reached (bit per code, unknown in bit 0): %b",
			formats_hit[5:0]);
		if (fail_count == 0 && codes_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Run timed out with %0d codes outstanding", codes_pending);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
